// ===== rtl/core/quadratic_root_solver_assert.svh =====
// assertion macros for the quadratic root solver
// used by the top level only, no other dependencies
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define QRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qrs assertion failed");

// condition must never hold
`define QRS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("qrs assertion failed");

`endif

// ===== rtl/core/qrs_pkg.sv =====
// shared constants, kind codes and transaction types of the quadratic root solver
// no dependencies
package qrs_pkg;

  localparam int unsigned CoefW    = 16;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RootW    = 48;
  localparam int unsigned KindW    = 3;

  localparam int unsigned ProdW    = 2 * CoefW;
  localparam int unsigned DiscW    = ProdW + 3;
  localparam int unsigned RadBits  = DiscW + 2 * FracBits;
  localparam int unsigned SqSteps  = (RadBits + 1) / 2;
  localparam int unsigned RadW     = 2 * SqSteps;
  localparam int unsigned SqrtW    = SqSteps;
  localparam int unsigned SqRemW   = SqrtW + 2;
  localparam int unsigned DvdW     = SqrtW + 2;
  localparam int unsigned NumSW    = DvdW + 1;
  localparam int unsigned DvsW     = CoefW + 1;
  localparam int unsigned DvSteps  = DvdW;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [KindW-1:0] KindInf  = 3'd0;
  localparam logic [KindW-1:0] KindNone = 3'd1;
  localparam logic [KindW-1:0] KindOne  = 3'd2;
  localparam logic [KindW-1:0] KindTwo  = 3'd3;
  localparam logic [KindW-1:0] KindCplx = 3'd4;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             zero_out;
    logic             lin;
    logic             lin_neg;
    logic             a_neg;
    logic             b_neg;
    logic [CoefW-1:0] am;
    logic [CoefW-1:0] bm;
    logic [CoefW-1:0] cm;
    logic [DiscW-1:0] disc;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic nearly_full;
  } qstat_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             zero_out;
    logic             neg1;
    logic             neg2;
  } dside_t;

endpackage

// ===== rtl/core/qrs_queue.sv =====
// short queue between the classify front and the root back end
// depends on qrs_pkg
module qrs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qrs_pkg::item_t  item_i,
  input  logic            pop_i,
  output qrs_pkg::item_t  head_o,
  output qrs_pkg::qstat_t stat_o
);

  qrs_pkg::item_t                mem_q [qrs_pkg::QDepth];
  logic [qrs_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [qrs_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [qrs_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign do_push = push_i && (cnt_q != qrs_pkg::QCntW'(qrs_pkg::QDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o             = mem_q[rd_ptr_q];
  assign stat_o.empty       = (cnt_q == '0);
  assign stat_o.full        = (cnt_q == qrs_pkg::QCntW'(qrs_pkg::QDepth));
  assign stat_o.nearly_full = (cnt_q >= qrs_pkg::QCntW'(qrs_pkg::QDepth - 2));

endmodule

// ===== rtl/core/qrs_front.sv =====
// front end: coefficient magnitudes, products, discriminant and root kind
// depends on qrs_pkg
module qrs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_vld_i,
  input  logic [qrs_pkg::CoefW-1:0] coef_a_i,
  input  logic [qrs_pkg::CoefW-1:0] coef_b_i,
  input  logic [qrs_pkg::CoefW-1:0] coef_c_i,
  output logic                      push_o,
  output qrs_pkg::item_t            item_o
);

  localparam int unsigned W = qrs_pkg::CoefW;

  logic                        s1_vld_q;
  logic [W-1:0]                am_q, bm_q, cm_q;
  logic                        a_neg_q, b_neg_q, c_neg_q;
  logic                        a_z_q, b_z_q, c_z_q;
  logic [qrs_pkg::ProdW-1:0]   b2_q, ac_q;
  logic [W-1:0]                am_d, bm_d, cm_d;

  logic                        s2_vld_q;
  qrs_pkg::item_t              item_q, item_d;

  logic [qrs_pkg::DiscW-1:0]   four_ac, b2_ext;
  logic                        ac_neg, d_neg;

  assign am_d = coef_a_i[W-1] ? W'(-coef_a_i) : coef_a_i;
  assign bm_d = coef_b_i[W-1] ? W'(-coef_b_i) : coef_b_i;
  assign cm_d = coef_c_i[W-1] ? W'(-coef_c_i) : coef_c_i;

  always_ff @(posedge clk_i) begin
    am_q    <= am_d;
    bm_q    <= bm_d;
    cm_q    <= cm_d;
    a_neg_q <= coef_a_i[W-1];
    b_neg_q <= coef_b_i[W-1];
    c_neg_q <= coef_c_i[W-1];
    a_z_q   <= (coef_a_i == '0);
    b_z_q   <= (coef_b_i == '0);
    c_z_q   <= (coef_c_i == '0);
    b2_q    <= bm_d * bm_d;
    ac_q    <= am_d * cm_d;
  end

  always_comb begin
    four_ac  = {1'b0, ac_q, 2'b00};
    b2_ext   = qrs_pkg::DiscW'(b2_q);
    ac_neg   = (ac_q != '0) && (a_neg_q != c_neg_q);
    d_neg    = !ac_neg && (four_ac > b2_ext);
    item_d.disc     = ac_neg ? (b2_ext + four_ac) : (d_neg ? '0 : (b2_ext - four_ac));
    item_d.lin      = a_z_q;
    item_d.lin_neg  = !c_z_q && (c_neg_q == b_neg_q);
    item_d.a_neg    = a_neg_q;
    item_d.b_neg    = b_neg_q;
    item_d.am       = am_q;
    item_d.bm       = bm_q;
    item_d.cm       = cm_q;
    item_d.zero_out = (a_z_q && b_z_q) || (!a_z_q && d_neg);
    if (a_z_q) begin
      if (b_z_q) begin
        item_d.kind = c_z_q ? qrs_pkg::KindInf : qrs_pkg::KindNone;
      end else begin
        item_d.kind = qrs_pkg::KindOne;
      end
    end else if (d_neg) begin
      item_d.kind = qrs_pkg::KindCplx;
    end else if (item_d.disc == '0) begin
      item_d.kind = qrs_pkg::KindOne;
    end else begin
      item_d.kind = qrs_pkg::KindTwo;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  assign push_o = s2_vld_q;
  assign item_o = item_q;

endmodule

// ===== rtl/core/qrs_back.sv =====
// back end: pipelined square root, numerators and two pipelined dividers
// depends on qrs_pkg
module qrs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_vld_i,
  input  qrs_pkg::item_t            item_i,
  output logic                      res_vld_o,
  output logic [qrs_pkg::KindW-1:0] res_kind_o,
  output logic [qrs_pkg::RootW-1:0] res_one_o,
  output logic [qrs_pkg::RootW-1:0] res_two_o
);

  localparam int unsigned SqN  = qrs_pkg::SqSteps;
  localparam int unsigned DvN  = qrs_pkg::DvSteps;
  localparam int unsigned RemW = qrs_pkg::SqRemW;
  localparam int unsigned SW   = qrs_pkg::SqrtW;
  localparam int unsigned RW   = qrs_pkg::RadW;
  localparam int unsigned DdW  = qrs_pkg::DvdW;
  localparam int unsigned DsW  = qrs_pkg::DvsW;
  localparam int unsigned NW   = qrs_pkg::NumSW;
  localparam int unsigned FB   = qrs_pkg::FracBits;

  logic [SqN-1:0]   sq_vld_q;
  logic [RemW-1:0]  sq_rem_q  [SqN];
  logic [SW-1:0]    sq_root_q [SqN];
  logic [RW-1:0]    sq_rad_q  [SqN];
  qrs_pkg::item_t   sq_item_q [SqN];

  for (genvar k = 0; k < SqN; k++) begin : g_sq
    logic [RemW-1:0] rem_in;
    logic [SW-1:0]   root_in;
    logic [RW-1:0]   rad_in;
    qrs_pkg::item_t  it_in;
    logic            v_in;
    logic [RemW+1:0] rem_try, trial;
    logic            ge;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {{(RW - qrs_pkg::DiscW - 2 * FB){1'b0}}, item_i.disc, {(2 * FB){1'b0}}};
      assign it_in   = item_i;
      assign v_in    = in_vld_i;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign it_in   = sq_item_q[k-1];
      assign v_in    = sq_vld_q[k-1];
    end
    assign rem_try = {rem_in, rad_in[RW-1 -: 2]};
    assign trial   = (RemW + 2)'({root_in, 2'b01});
    assign ge      = (rem_try >= trial);

    always_ff @(posedge clk_i) begin
      sq_rad_q[k]  <= {rad_in[RW-3:0], 2'b00};
      sq_item_q[k] <= it_in;
      if (ge) begin
        sq_rem_q[k]  <= RemW'(rem_try - trial);
        sq_root_q[k] <= {root_in[SW-2:0], 1'b1};
      end else begin
        sq_rem_q[k]  <= rem_try[RemW-1:0];
        sq_root_q[k] <= {root_in[SW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= v_in;
      end
    end
  end

  qrs_pkg::item_t    nm_it;
  logic signed [NW-1:0] nb, n1, n2, s_ext;
  logic [DdW-1:0]    m1, m2;
  logic              nm_vld_q;
  qrs_pkg::dside_t   nm_side_q, nm_side_d;
  logic [DdW-1:0]    nm_dvd1_q, nm_dvd2_q, nm_dvd1_d, nm_dvd2_d;
  logic [DsW-1:0]    nm_dvs_q, nm_dvs_d;

  assign nm_it = sq_item_q[SqN-1];

  always_comb begin
    s_ext = NW'(sq_root_q[SqN-1]);
    nb    = NW'({nm_it.bm, {FB{1'b0}}});
    if (!nm_it.b_neg) begin
      nb = -nb;
    end
    n1 = nb + s_ext;
    n2 = nb - s_ext;
    m1 = DdW'(n1[NW-1] ? -n1 : n1);
    m2 = DdW'(n2[NW-1] ? -n2 : n2);
    nm_side_d.kind     = nm_it.kind;
    nm_side_d.zero_out = nm_it.zero_out;
    if (nm_it.lin) begin
      nm_dvd1_d      = DdW'({nm_it.cm, {FB{1'b0}}});
      nm_dvd2_d      = nm_dvd1_d;
      nm_dvs_d       = DsW'(nm_it.bm);
      nm_side_d.neg1 = nm_it.lin_neg;
      nm_side_d.neg2 = nm_it.lin_neg;
    end else begin
      nm_dvd1_d      = m1;
      nm_dvd2_d      = m2;
      nm_dvs_d       = {nm_it.am, 1'b0};
      nm_side_d.neg1 = n1[NW-1] ^ nm_it.a_neg;
      nm_side_d.neg2 = n2[NW-1] ^ nm_it.a_neg;
    end
  end

  always_ff @(posedge clk_i) begin
    nm_side_q <= nm_side_d;
    nm_dvd1_q <= nm_dvd1_d;
    nm_dvd2_q <= nm_dvd2_d;
    nm_dvs_q  <= nm_dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q <= 1'b0;
    end else begin
      nm_vld_q <= sq_vld_q[SqN-1];
    end
  end

  logic [DvN-1:0]   dv_vld_q;
  qrs_pkg::dside_t  dv_side_q [DvN];
  logic [DsW-1:0]   dv_dvs_q  [DvN];
  logic [DsW-1:0]   dv_rem_q  [DvN][2];
  logic [DdW-1:0]   dv_quo_q  [DvN][2];
  logic [DdW-1:0]   dv_dvd_q  [DvN][2];

  for (genvar k = 0; k < DvN; k++) begin : g_dv
    qrs_pkg::dside_t side_in;
    logic [DsW-1:0]  dvs_in;
    logic            v_in;
    always_ff @(posedge clk_i) begin
      dv_side_q[k] <= side_in;
      dv_dvs_q[k]  <= dvs_in;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= v_in;
      end
    end
    if (k == 0) begin : g_first
      assign side_in = nm_side_q;
      assign dvs_in  = nm_dvs_q;
      assign v_in    = nm_vld_q;
    end else begin : g_next
      assign side_in = dv_side_q[k-1];
      assign dvs_in  = dv_dvs_q[k-1];
      assign v_in    = dv_vld_q[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DsW-1:0] rem_in;
      logic [DdW-1:0] quo_in, dvd_in;
      logic [DsW:0]   r_try, dvs_ext;
      logic           ge;
      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign quo_in = '0;
        assign dvd_in = (l == 0) ? nm_dvd1_q : nm_dvd2_q;
      end else begin : g_next
        assign rem_in = dv_rem_q[k-1][l];
        assign quo_in = dv_quo_q[k-1][l];
        assign dvd_in = dv_dvd_q[k-1][l];
      end
      assign r_try   = {rem_in, dvd_in[DdW-1]};
      assign dvs_ext = {1'b0, dvs_in};
      assign ge      = (r_try >= dvs_ext);
      always_ff @(posedge clk_i) begin
        dv_dvd_q[k][l] <= {dvd_in[DdW-2:0], 1'b0};
        dv_quo_q[k][l] <= {quo_in[DdW-2:0], ge};
        dv_rem_q[k][l] <= ge ? DsW'(r_try - dvs_ext) : r_try[DsW-1:0];
      end
    end
  end

  logic                      out_vld_q;
  logic [qrs_pkg::KindW-1:0] out_kind_q;
  logic [qrs_pkg::RootW-1:0] out_one_q, out_two_q, q1, q2;
  qrs_pkg::dside_t           last_side;

  assign last_side = dv_side_q[DvN-1];
  assign q1 = qrs_pkg::RootW'(dv_quo_q[DvN-1][0]);
  assign q2 = qrs_pkg::RootW'(dv_quo_q[DvN-1][1]);

  always_ff @(posedge clk_i) begin
    out_kind_q <= last_side.kind;
    out_one_q  <= last_side.zero_out ? '0 : (last_side.neg1 ? -q1 : q1);
    out_two_q  <= last_side.zero_out ? '0 : (last_side.neg2 ? -q2 : q2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld_q[DvN-1];
    end
  end

  assign res_vld_o  = out_vld_q;
  assign res_kind_o = out_kind_q;
  assign res_one_o  = out_one_q;
  assign res_two_o  = out_two_q;

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// top level of the quadratic root solver: front end, queue and back end
// depends on qrs_pkg, qrs_front, qrs_queue, qrs_back and quadratic_root_solver_assert.svh
//
// usage
//   a transaction is accepted at a rising edge with start_i high and busy_o low;
//   coef_a_i, coef_b_i, coef_c_i are 16 bit two's complement coefficients
//   one result per transaction: valid_o is high for exactly one cycle with
//   root_kind_o, root_one_o and root_two_o (48 bit, 16 fraction bits)
//   from the accepting edge to the edge that takes the result an item passes
//   2 front stages, the queue, 34 square root steps (one radicand bit pair per
//   stage), a numerator stage, 36 divide steps per root and an output register
//   throughput one transaction per cycle while busy_o is low; busy_o only
//   rises if the queue holds two or more items; results are in transaction
//   order; the receiver cannot stall, so results are never held
//   reset clears every valid bit and the queue; payload registers are not reset
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [qrs_pkg::CoefW-1:0] coef_a_i,
  input  logic [qrs_pkg::CoefW-1:0] coef_b_i,
  input  logic [qrs_pkg::CoefW-1:0] coef_c_i,
  output logic                      valid_o,
  output logic [qrs_pkg::KindW-1:0] root_kind_o,
  output logic [qrs_pkg::RootW-1:0] root_one_o,
  output logic [qrs_pkg::RootW-1:0] root_two_o
);

  logic            in_vld, push, q_vld;
  qrs_pkg::item_t  front_item, head_item;
  qrs_pkg::qstat_t q_stat;
  logic            absent_kind, single_kind;

  assign in_vld = start_i && !busy_o;
  assign busy_o = q_stat.nearly_full;
  assign q_vld  = !q_stat.empty;

  qrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (in_vld),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .push_o   (push),
    .item_o   (front_item)
  );

  qrs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (q_vld),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  qrs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (q_vld),
    .item_i     (head_item),
    .res_vld_o  (valid_o),
    .res_kind_o (root_kind_o),
    .res_one_o  (root_one_o),
    .res_two_o  (root_two_o)
  );

  assign absent_kind = (root_kind_o == qrs_pkg::KindInf) ||
                       (root_kind_o == qrs_pkg::KindNone) ||
                       (root_kind_o == qrs_pkg::KindCplx);
  assign single_kind = (root_kind_o == qrs_pkg::KindOne);

  `QRS_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, push && q_stat.full)
  `QRS_ASSERT_IMP(a_absent_roots_zero, clk_i, rst_ni, valid_o && absent_kind, (root_one_o == '0) && (root_two_o == '0))
  `QRS_ASSERT_IMP(a_single_root_equal, clk_i, rst_ni, valid_o && single_kind, root_one_o == root_two_o)

endmodule

// ===== sim/tb_quadratic_root_solver.sv =====
// self-checking testbench for quadratic_root_solver: queued driver, clocked monitor
// expected kind and fixed-point roots come from an independent integer solver below
// depends on qrs_pkg and the quadratic_root_solver rtl
module tb_quadratic_root_solver;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  typedef struct {
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] c;
  } coef_set_t;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [RootW-1:0] r1;
    logic [RootW-1:0] r2;
  } roots_t;

  localparam int NumRandom = 750;
  localparam int DrainCycles = 120;
  localparam longint CycleLimit = 400000;

  logic clk_i, rst_ni, start_i, busy_o, valid_o;
  logic [CoefW-1:0] coef_a_i, coef_b_i, coef_c_i;
  logic [KindW-1:0] root_kind_o;
  logic [RootW-1:0] root_one_o, root_two_o;

  coef_set_t pending_q[$];
  roots_t    roots_q[$];
  int        errors = 0;
  int        sent = 0;
  int        total = 0;
  longint    cycles = 0;

  quadratic_root_solver u_dut (.*);

  function automatic logic [63:0] isqrt_floor(logic [127:0] v);
    logic [63:0] root;
    logic [67:0] rem, trial;
    root = '0;
    rem  = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | v[2*i +: 2];
      trial = ({4'b0, root} << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [RootW-1:0] saturate_root(bit neg, logic [127:0] q);
    logic [127:0] lim;
    lim = neg ? (128'd1 << (RootW - 1)) : ((128'd1 << (RootW - 1)) - 1);
    if (q > lim) q = lim;
    return neg ? RootW'(-q) : RootW'(q);
  endfunction

  function automatic logic [RootW-1:0] div_by_two_a(longint n, longint a);
    logic [127:0] q;
    bit neg;
    q   = (n < 0 ? -n : n) / (2 * (a < 0 ? -a : a));
    neg = (n < 0) != (a < 0);
    return saturate_root(neg && q != 0, q);
  endfunction

  function automatic roots_t solve_quadratic(coef_set_t s);
    roots_t r;
    longint a, b, c, disc, nb, sq;
    logic [127:0] q;
    bit neg;
    a = longint'($signed(s.a));
    b = longint'($signed(s.b));
    c = longint'($signed(s.c));
    r.r1 = '0;
    r.r2 = '0;
    if (a == 0) begin
      if (b == 0) begin
        r.kind = (c == 0) ? KindInf : KindNone;
      end else begin
        q      = (128'(c < 0 ? -c : c) << FracBits) / 128'(b < 0 ? -b : b);
        neg    = (c != 0) && ((c > 0) == (b > 0));
        r.kind = KindOne;
        r.r1   = saturate_root(neg && q != 0, q);
        r.r2   = r.r1;
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        r.kind = KindCplx;
      end else begin
        sq     = longint'(isqrt_floor(128'(disc) << (2 * FracBits)));
        nb     = -b * (longint'(1) << FracBits);
        r.kind = (disc == 0) ? KindOne : KindTwo;
        r.r1   = div_by_two_a(nb + sq, a);
        r.r2   = div_by_two_a(nb - sq, a);
      end
    end
    return r;
  endfunction

  function automatic coef_set_t mk(int a, int b, int c);
    coef_set_t s;
    s.a = CoefW'(a);
    s.b = CoefW'(b);
    s.c = CoefW'(c);
    return s;
  endfunction

  function automatic coef_set_t random_set();
    int a, r;
    case ($urandom_range(0, 6))
      0: return mk(0, $urandom, $urandom);
      1: return mk(0, 0, $urandom_range(0, 3) == 0 ? 0 : $urandom);
      2: begin
        a = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
        r = $signed($urandom_range(0, 40)) - 20;
        return mk(a, -2 * a * r, a * r * r);
      end
      3: return mk($signed($urandom_range(0, 40)) - 20, $signed($urandom_range(0, 200)) - 100,
                   $signed($urandom_range(0, 40)) - 20);
      4: return mk($urandom_range(0, 1) ? 32767 : -32768, $urandom,
                   $urandom_range(0, 1) ? 32767 : -32768);
      default: return mk($urandom, $urandom, $urandom);
    endcase
  endfunction

  function automatic int idle_percent();
    case ((sent * 4) / (total == 0 ? 1 : total))
      1: return 57;
      3: return 36;
      default: return 0;
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        roots_q.push_back(solve_quadratic(pending_q[0]));
        void'(pending_q.pop_front());
        sent++;
      end
      if (pending_q.size() > 0 && $urandom_range(1, 100) > idle_percent()) begin
        start_i  <= 1'b1;
        coef_a_i <= pending_q[0].a;
        coef_b_i <= pending_q[0].b;
        coef_c_i <= pending_q[0].c;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni && valid_o) begin
      if (roots_q.size() == 0) begin
        $error("unexpected transaction kind=%0d", root_kind_o);
        errors++;
      end else begin
        e = roots_q.pop_front();
        if (root_kind_o !== e.kind) begin
          $error("root_kind expected %0d actual %0d", e.kind, root_kind_o);
          errors++;
        end
        if (root_one_o !== e.r1) begin
          $error("root_one expected %h actual %h", e.r1, root_one_o);
          errors++;
        end
        if (root_two_o !== e.r2) begin
          $error("root_two expected %h actual %h", e.r2, root_two_o);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    coef_a_i = '0;
    coef_b_i = '0;
    coef_c_i = '0;
    pending_q.push_back(mk(0, 0, 0));
    pending_q.push_back(mk(0, 0, 5));
    pending_q.push_back(mk(0, 0, -32768));
    pending_q.push_back(mk(0, 1, 0));
    pending_q.push_back(mk(0, 3, 7));
    pending_q.push_back(mk(0, -32768, 32767));
    pending_q.push_back(mk(0, 1, -32768));
    pending_q.push_back(mk(0, -1, 32767));
    pending_q.push_back(mk(1, 2, 1));
    pending_q.push_back(mk(-3, 6, -3));
    pending_q.push_back(mk(1, 0, 1));
    pending_q.push_back(mk(1, 0, -1));
    pending_q.push_back(mk(2, -7, 3));
    pending_q.push_back(mk(5, 0, 0));
    pending_q.push_back(mk(-32768, -32768, 32767));
    pending_q.push_back(mk(32767, -32768, -32768));
    pending_q.push_back(mk(-32768, 32767, -32768));
    pending_q.push_back(mk(32767, 32767, 32767));
    pending_q.push_back(mk(1, -32768, 0));
    pending_q.push_back(mk(-1, 32767, 32767));
    pending_q.push_back(mk(-32768, 0, 0));
    for (int i = 0; i < NumRandom; i++) pending_q.push_back(random_set());
    total = pending_q.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && roots_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && roots_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
